// File: sv/bsw_pkg.sv
// Shared types and constants of the box window sum core.
// Depends on nothing; every other file imports it.
`default_nettype none

package bsw_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int SUM_BITS        = 29;
   localparam int ROW_BITS        = 13;
   localparam int HEIGHT_LIMIT    = 4096;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_WIDTH_BITS  = 10;
   localparam int CSR_WINDOW_BITS = 3;
   // holds the output lag and the result index within one word, for windows up to 9
   localparam int LAG_BITS        = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SIZE  = CSR_INDEX_BITS'(2);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          fill;
   } bsw_req_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] window_sum;
      logic                       last_of_run;
      logic                       last_of_frame;
   } bsw_rsp_type;

   // what one column word asks of the result stage
   typedef struct packed {
      logic                emit;
      logic                frame_last;
      logic [LAG_BITS-1:0] t_first;
      logic [LAG_BITS-1:0] t_last;
   } bsw_col_ctl_type;

endpackage

`default_nettype wire

// File: sv/bsw_line_store.sv
// Line store: one memory word per column holding the previous rows of that column.
// Read-modify-write with a registered read and a bypass on a same-address write.
// Depends on bsw_pkg.
`default_nettype none

module bsw_line_store
   import bsw_pkg::*;
#(
   parameter int DEPTH  = 512,
   parameter int HIST_N = 4
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [SAMPLE_BITS-1:0]       wr_sample,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [HIST_N-1:0][SAMPLE_BITS-1:0]  hist
);

   logic [HIST_N-1:0][SAMPLE_BITS-1:0] line_mem_ff [DEPTH];
   logic [HIST_N-1:0][SAMPLE_BITS-1:0] hist_ff;
   logic [HIST_N-1:0][SAMPLE_BITS-1:0] wr_word;

   // push the new sample in, age the older rows by one
   always_comb begin
      wr_word[0] = wr_sample;
      for (int k = 1; k < HIST_N; k++) begin
         wr_word[k] = hist_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_word;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         hist_ff <= wr_word;
      end else begin
         hist_ff <= line_mem_ff[rd_addr];
      end
   end

   assign hist = hist_ff;

endmodule

`default_nettype wire

// File: sv/bsw_window_sum.sv
// Window registers of column sums and the result sequencer with its output register.
// Gives one result word per cycle while rsp_ready is high; an end-of-row column can give several.
// Depends on bsw_pkg.
`default_nettype none

module bsw_window_sum
   import bsw_pkg::*;
#(
   parameter int MAX_WINDOW = 5,
   parameter int MAX_WIDTH  = 512
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               col_valid,
   output logic                                               col_ready,
   input  logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]   col_sum,
   input  logic [$clog2(MAX_WIDTH)-1:0]                       col_idx,
   input  bsw_col_ctl_type                                    col_ctl,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]                    win,
   output logic                                               rsp_valid,
   input  logic                                               rsp_ready,
   output bsw_rsp_type                                        rsp_data
);

   localparam int COLSUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int ACC_NEED    = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW);
   localparam int ACC_BITS    = (ACC_NEED > SUM_BITS) ? ACC_NEED : SUM_BITS;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);

   logic signed [COLSUM_BITS-1:0] taps_ff [MAX_WINDOW];

   logic                  s2_valid_ff, s2_valid_in;
   logic [COL_BITS-1:0]   s2_col_ff;
   bsw_col_ctl_type       s2_ctl_ff;
   logic [LAG_BITS-1:0]   s2_t_ff, s2_t_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   bsw_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  out_free, s2_fire, s2_end, s2_done, take, emit;
   logic signed [ACC_BITS-1:0] acc;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_fire   = s2_valid_ff && (!s2_ctl_ff.emit || out_free);
   assign s2_end    = (s2_t_ff == s2_ctl_ff.t_last);
   assign s2_done   = s2_fire && (!s2_ctl_ff.emit || s2_end);
   assign col_ready = !s2_valid_ff || s2_done;
   assign take      = col_valid && col_ready;
   assign emit      = s2_fire && s2_ctl_ff.emit;

   // result t drops the t rightmost-but-out-of-image columns; taps left of column 0 are zero
   always_comb begin
      acc = '0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if ((k + int'(s2_t_ff) < int'(win)) && (k <= int'(s2_col_ff))) begin
            acc = acc + ACC_BITS'(taps_ff[k]);
         end
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_t_in     = s2_t_ff;
      if (take) begin
         s2_valid_in = 1'b1;
         s2_t_in     = col_ctl.t_first;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end else if (emit) begin
         s2_t_in = s2_t_ff + LAG_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in              = emit || (rsp_valid_ff && !rsp_ready);
      rsp_data_in.window_sum    = acc[SUM_BITS-1:0];
      rsp_data_in.last_of_run   = s2_end;
      rsp_data_in.last_of_frame = s2_ctl_ff.frame_last && s2_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_t_ff <= s2_t_in;
      if (take) begin
         taps_ff[0] <= col_sum;
         for (int k = 1; k < MAX_WINDOW; k++) begin
            taps_ff[k] <= taps_ff[k-1];
         end
         s2_col_ff <= col_idx;
         s2_ctl_ff <= col_ctl;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/same_size_box_window_sum_core.sv
// Top level of the zero-padded same-size box window sum over a raster stream.
// Depends on bsw_pkg, bsw_line_store and bsw_window_sum.
//
//   port group  | direction | handshake            | word
//   req_*       | in        | req_valid/req_ready  | bsw_req_type (sample, fill)
//   rsp_*       | out       | rsp_valid/rsp_ready  | bsw_rsp_type (window_sum, last flags)
//   csr_*       | in        | csr_wr_en only       | csr_index, csr_wdata
//
// One input word per cycle while req_ready is high. A word that ends an output row gives up to
// lag+1 results and holds the result sequencer while it gives them, with lag =
// window_size-1-floor(window_size/2). A result word is registered in turn in the s1
// register, the s2 window registers and the output register.
// Reset is synchronous; no clearing pass, history rows above the top are masked by
// the row counter. A low rsp_ready holds the output register and backs up to req_ready.
`default_nettype none

module same_size_box_window_sum_core
   import bsw_pkg::*;
#(
   parameter int MAX_WINDOW = 5,
   parameter int MAX_WIDTH  = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  bsw_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bsw_rsp_type                rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int WIN_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int HIST_N        = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
   localparam int COLSUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int WIDTH_RST_VAL = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
   localparam int WIN_RST_VAL   = (MAX_WINDOW < 5) ? MAX_WINDOW : 5;

   // configuration, held as effective values
   logic [WIDTH_BITS-1:0]       width_ff, width_in;
   logic [ROW_BITS-1:0]         height_ff, height_in;
   logic [WIN_BITS-1:0]         win_ff, win_in;
   logic                        csr_hit;
   logic [CSR_WIDTH_BITS-1:0]   csr_width_raw;
   logic [ROW_BITS-1:0]         csr_height_raw;
   logic [CSR_WINDOW_BITS-1:0]  csr_win_raw;

   logic [COL_BITS-1:0]         col_ff, col_in;
   logic [ROW_BITS-1:0]         row_ff, row_in;

   logic                        accept;
   logic [LAG_BITS-1:0]         lag;
   logic [ROW_BITS-1:0]         lag_row;
   logic [WIDTH_BITS-1:0]       lag_col, col_w;
   logic                        last_col, in_rows, frame_last, past_lag;
   logic signed [SAMPLE_BITS-1:0] eff_sample;
   bsw_col_ctl_type             col_ctl;
   logic [HIST_N-1:0][SAMPLE_BITS-1:0] hist;

   logic                        s1_valid_ff, s1_valid_in;
   logic signed [COLSUM_BITS-1:0] s1_colsum_ff, colsum_in;
   logic [COL_BITS-1:0]         s1_col_ff;
   bsw_col_ctl_type             s1_ctl_ff;
   logic                        win_ready;

   assign csr_width_raw  = csr_wdata[CSR_WIDTH_BITS-1:0];
   assign csr_height_raw = csr_wdata[ROW_BITS-1:0];
   assign csr_win_raw    = csr_wdata[CSR_WINDOW_BITS-1:0];

   // clamp register writes to the supported range
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      win_in    = win_ff;
      csr_hit   = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               csr_hit = 1'b1;
               if (csr_width_raw == '0) begin
                  width_in = WIDTH_BITS'(1);
               end else if (int'(csr_width_raw) > MAX_WIDTH) begin
                  width_in = WIDTH_BITS'(MAX_WIDTH);
               end else begin
                  width_in = WIDTH_BITS'(csr_width_raw);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               csr_hit = 1'b1;
               if (csr_height_raw == '0) begin
                  height_in = ROW_BITS'(1);
               end else if (int'(csr_height_raw) > HEIGHT_LIMIT) begin
                  height_in = ROW_BITS'(HEIGHT_LIMIT);
               end else begin
                  height_in = csr_height_raw;
               end
            end
            CSR_WINDOW_SIZE: begin
               csr_hit = 1'b1;
               if (csr_win_raw == '0) begin
                  win_in = WIN_BITS'(1);
               end else if (int'(csr_win_raw) > MAX_WINDOW) begin
                  win_in = WIN_BITS'(MAX_WINDOW);
               end else begin
                  win_in = WIN_BITS'(csr_win_raw);
               end
            end
            default: ;
         endcase
      end
   end

   assign accept     = req_valid && req_ready;
   assign lag        = LAG_BITS'(win_ff - WIN_BITS'(1) - (win_ff >> 1));
   assign lag_row    = ROW_BITS'(lag);
   assign lag_col    = WIDTH_BITS'(lag);
   assign col_w      = WIDTH_BITS'(col_ff);
   assign last_col   = (col_w == width_ff - WIDTH_BITS'(1));
   assign in_rows    = (row_ff >= lag_row) && (row_ff < height_ff + lag_row);
   assign frame_last = last_col && (row_ff == height_ff - ROW_BITS'(1) + lag_row);
   assign past_lag   = (col_w >= lag_col);
   assign eff_sample = (req_data.fill || (row_ff >= height_ff)) ? '0 : req_data.sample;

   always_comb begin
      col_ctl.emit       = in_rows && (last_col || past_lag);
      col_ctl.frame_last = frame_last;
      col_ctl.t_first    = past_lag ? '0 : LAG_BITS'(lag_col - col_w);
      col_ctl.t_last     = last_col ? lag : '0;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (frame_last) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // vertical sum over the window rows; drop history rows that lie above the top of the frame
   always_comb begin
      colsum_in = COLSUM_BITS'(eff_sample);
      for (int k = 0; k < HIST_N; k++) begin
         if ((k + 1 < int'(win_ff)) && (int'(row_ff) > k)) begin
            colsum_in = colsum_in + COLSUM_BITS'($signed(hist[k]));
         end
      end
   end

   assign req_ready   = !s1_valid_ff || win_ready;
   assign s1_valid_in = accept || (s1_valid_ff && !win_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_BITS'(WIDTH_RST_VAL);
         height_ff   <= ROW_BITS'(512);
         win_ff      <= WIN_BITS'(WIN_RST_VAL);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         win_ff      <= win_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_colsum_ff <= colsum_in;
         s1_col_ff    <= col_ff;
         s1_ctl_ff    <= col_ctl;
      end
   end

   // read ahead at the next column so its history is ready on acceptance
   bsw_line_store #(
      .DEPTH  (MAX_WIDTH),
      .HIST_N (HIST_N)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col_ff),
      .wr_sample (eff_sample),
      .rd_addr   (col_in),
      .hist      (hist)
   );

   bsw_window_sum #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_window_sum (
      .clock     (clock),
      .reset     (reset),
      .col_valid (s1_valid_ff),
      .col_ready (win_ready),
      .col_sum   (s1_colsum_ff),
      .col_idx   (s1_col_ff),
      .col_ctl   (s1_ctl_ff),
      .win       (win_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: sv/bsw_port_checker.sv
// Port checks on the result channel of the box window sum core, bound to the top level.
// Depends on bsw_pkg and same_size_box_window_sum_core.
`default_nettype none

module bsw_port_checker
   import bsw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input bsw_rsp_type rsp_data
);

   // no result may survive a reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // the bottom-right result always closes its run
   a_frame_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_frame |-> rsp_data.last_of_run)
      else $error("frame end without run end");

endmodule

bind same_size_box_window_sum_core bsw_port_checker u_port_checker (.*);

`default_nettype wire
